// ===== design/photon_intensity_binner_defines.svh =====
// Assertion macros used by the checker file of the photon binner.
// No dependencies; included by bare file name.
`ifndef PHOTON_INTENSITY_BINNER_DEFINES_SVH
`define PHOTON_INTENSITY_BINNER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PIB_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("pib assertion failed");

// Next-cycle implication, disabled during reset.
`define PIB_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("pib assertion failed");

`endif

// ===== design/pib_pkg.sv =====
// Package of the photon intensity binner: sizes, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pib_pkg;
	localparam int BINS           = 16;
	localparam int CHANNELS       = 4;
	localparam int QUEUE_DEPTH    = 256;
	localparam int CMD_FIFO_DEPTH = 2;

	localparam int TIME_W  = 48;
	localparam int EDGE_W  = 32;
	localparam int COUNT_W = 32;
	localparam int BIN_W   = 4;
	localparam int CH_W    = 2;
	localparam int EIDX_W  = BIN_W + 1;
	localparam int CNT_AW  = BIN_W + CH_W;
	localparam int QA_W    = 8;
	localparam int LVL_W   = QA_W + 1;
	localparam int SUM_W   = TIME_W + 2;
	localparam int CNT_DEPTH = BINS * CHANNELS;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_PHOTON = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_READ   = 2'd3
	} opcode_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ERROR   = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	localparam logic [2:0] REG_START_EN   = 3'd0;
	localparam logic [2:0] REG_START_TIME = 3'd1;
	localparam logic [2:0] REG_STOP_EN    = 3'd2;
	localparam logic [2:0] REG_STOP_TIME  = 3'd3;
	localparam logic [2:0] REG_MAX_DELAY  = 3'd4;

	typedef struct packed {
		opcode_t                    op;
		logic [TIME_W-1:0]          photon_time;
		logic [CH_W-1:0]            photon_channel;
		logic [EIDX_W-1:0]          edge_index;
		logic signed [EDGE_W-1:0]   edge_value;
		logic [BIN_W-1:0]           bin_index;
		logic [CH_W-1:0]            read_channel;
		logic                       edge_ok;
		logic                       read_ok;
	} cmd_t;

	typedef struct packed {
		logic              start_enable;
		logic [TIME_W-1:0] start_stamp;
		logic              stop_enable;
		logic [TIME_W-1:0] stop_stamp;
		logic [TIME_W-1:0] max_delay;
	} cfg_t;
endpackage
`default_nettype wire

// ===== design/pib_front.sv =====
// Front end: takes command beats, decodes range checks, holds one beat.
// Depends on pib_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pib_front import pib_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [1:0]               opcode,
	input  wire logic [TIME_W-1:0]        photon_time,
	input  wire logic [CH_W-1:0]          photon_channel,
	input  wire logic [EIDX_W-1:0]        edge_index,
	input  wire logic signed [EDGE_W-1:0] edge_value,
	input  wire logic [BIN_W-1:0]         bin_index,
	input  wire logic [CH_W-1:0]          read_channel,
	input  wire logic                     fifo_full,
	output logic                          busy,
	output logic                          push,
	output cmd_t                          cmd
);
	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;

	assign busy   = valid_s1 & fifo_full;
	assign push   = valid_s1 & ~fifo_full;
	assign accept = start & ~busy;
	assign cmd    = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~push);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op             <= opcode_t'(opcode);
			cmd_s1.photon_time    <= photon_time;
			cmd_s1.photon_channel <= photon_channel;
			cmd_s1.edge_index     <= edge_index;
			cmd_s1.edge_value     <= edge_value;
			cmd_s1.bin_index      <= bin_index;
			cmd_s1.read_channel   <= read_channel;
			cmd_s1.edge_ok        <= ({1'b0, edge_index} <= (EIDX_W+1)'(BINS));
			cmd_s1.read_ok        <= ({1'b0, bin_index} < (BIN_W+1)'(BINS)) &&
				({1'b0, read_channel} < (CH_W+1)'(CHANNELS));
		end
	end
endmodule
`default_nettype wire

// ===== design/pib_cmd_fifo.sv =====
// Short command queue between front and back ends.
// Depends on pib_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pib_cmd_fifo import pib_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output logic      full,
	output logic      empty,
	output cmd_t      head_cmd
);
	localparam int PW = $clog2(CMD_FIFO_DEPTH);
	cmd_t entries[CMD_FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full     = (cnt_q == (PW+1)'(CMD_FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_cmd = entries[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(CMD_FIFO_DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PW'(CMD_FIFO_DEPTH-1)) ? '0 : rd_q + 1'b1;
			if (push & ~pop) cnt_q <= cnt_q + 1'b1;
			else if (pop & ~push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries[wr_q] <= push_cmd;
	end
endmodule
`default_nettype wire

// ===== design/pib_back.sv =====
// Back end: delay queue, bin walk over the edge table, count table, results.
// Depends on pib_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pib_back import pib_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cfg_t         cfg,
	input  wire logic         fifo_empty,
	input  wire cmd_t         fifo_cmd,
	output logic              pop,
	output logic              done,
	output logic [1:0]        status,
	output logic [COUNT_W-1:0] count_value,
	output logic [LVL_W-1:0]  queue_level
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_EXEC  = 8'b0000_0010,
		S_READ  = 8'b0000_0100,
		S_DCHK  = 8'b0000_1000,
		S_QWAIT = 8'b0001_0000,
		S_BLO   = 8'b0010_0000,
		S_BHI   = 8'b0100_0000,
		S_BUPD  = 8'b1000_0000
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;
	logic [QA_W-1:0]   head_q;
	logic [LVL_W-1:0]  fill_q;
	logic [TIME_W-1:0] front_q, back_q, ptime_q;
	logic [CH_W-1:0]   pch_q;
	logic started_q, error_q, flushed_q, flush_mode_q, hit_q;
	logic [BIN_W-1:0] bin_q;
	logic signed [EDGE_W-1:0] lo_edge_q, hi_edge_q;
	logic done_q;
	logic [1:0] status_q;
	logic [COUNT_W-1:0] count_q;
	logic [LVL_W-1:0] level_q;

	// memories
	logic [TIME_W-1:0] qt_mem[QUEUE_DEPTH];
	logic [CH_W-1:0]   qc_mem[QUEUE_DEPTH];
	logic [TIME_W-1:0] qt_rd_q;
	logic [CH_W-1:0]   qc_rd_q;
	logic signed [EDGE_W-1:0] edge_mem[BINS+1];
	logic [BINS:0]     edge_vld_q;
	logic signed [EDGE_W-1:0] e_rd_q;
	logic              e_rd_vld_q;
	logic [COUNT_W-1:0] cnt_mem[CNT_DEPTH];
	logic [CNT_DEPTH-1:0] cnt_vld_q;
	logic [COUNT_W-1:0] c_rd_q;
	logic               c_rd_vld_q;

	logic q_we, e_we, c_we;
	logic [QA_W-1:0]   q_waddr;
	logic [EIDX_W-1:0] e_raddr;
	logic [CNT_AW-1:0] c_raddr, c_waddr;
	logic [COUNT_W-1:0] c_base, c_wdata;

	logic signed [EDGE_W-1:0] hi_edge;
	logic signed [SUM_W-1:0]  lo_sum, hi_sum, front_s, back_s;
	logic hit;
	logic signed [SUM_W-1:0] age, max_s;
	logic due;
	logic early;

	assign pop         = (state_q == S_IDLE) & ~fifo_empty;
	assign done        = done_q;
	assign status      = status_q;
	assign count_value = count_q;
	assign queue_level = level_q;

	assign q_waddr = head_q + fill_q[QA_W-1:0];
	assign early   = ~started_q & cfg.start_enable & (cmd_q.photon_time < cfg.start_stamp);
	assign q_we    = (state_q == S_EXEC) & ~flushed_q & ~error_q &
		(cmd_q.op == OP_PHOTON) & ~early & (fill_q != LVL_W'(QUEUE_DEPTH));
	assign e_we    = (state_q == S_EXEC) & (cmd_q.op == OP_LOAD) & cmd_q.edge_ok;

	always_comb begin
		unique case (state_q)
			S_BLO:   e_raddr = {1'b0, bin_q} + EIDX_W'(1);
			S_BUPD:  e_raddr = (bin_q == BIN_W'(BINS-1)) ? '0 : {1'b0, bin_q} + EIDX_W'(2);
			default: e_raddr = '0;
		endcase
	end

	assign c_raddr = (state_q == S_EXEC) ? {cmd_q.bin_index, cmd_q.read_channel}
		: {bin_q, pch_q};
	assign c_waddr = {bin_q, pch_q};
	assign c_base  = c_rd_vld_q ? c_rd_q : '0;
	assign c_wdata = (c_base == '1) ? c_base : c_base + 1'b1;
	assign c_we    = (state_q == S_BUPD) & hit_q & ({1'b0, pch_q} < (CH_W+1)'(CHANNELS));

	// window test: a bin counts if either boundary falls in [front, back)
	assign hi_edge = e_rd_vld_q ? e_rd_q : '0;
	assign lo_sum  = $signed({2'b00, ptime_q}) + SUM_W'(lo_edge_q);
	assign hi_sum  = $signed({2'b00, ptime_q}) + SUM_W'(hi_edge);
	assign front_s = $signed({2'b00, front_q});
	assign back_s  = $signed({2'b00, back_q});
	assign hit     = ((front_s <= lo_sum) && (lo_sum < back_s)) ||
		((front_s <= hi_sum) && (hi_sum < back_s));

	assign age   = $signed({2'b00, back_q}) - $signed({2'b00, qt_rd_q});
	assign max_s = $signed({2'b00, cfg.max_delay});
	assign due   = flush_mode_q | (age > max_s);

	always_ff @(posedge clk) begin
		if (q_we) begin
			qt_mem[q_waddr] <= cmd_q.photon_time;
			qc_mem[q_waddr] <= cmd_q.photon_channel;
		end
		qt_rd_q <= qt_mem[head_q];
		qc_rd_q <= qc_mem[head_q];
		if (e_we) edge_mem[cmd_q.edge_index] <= cmd_q.edge_value;
		e_rd_q <= edge_mem[e_raddr];
		if (c_we) cnt_mem[c_waddr] <= c_wdata;
		c_rd_q <= cnt_mem[c_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_vld_q <= '0;
			e_rd_vld_q <= 1'b0;
			cnt_vld_q  <= '0;
			c_rd_vld_q <= 1'b0;
		end else begin
			if (e_we) edge_vld_q[cmd_q.edge_index] <= 1'b1;
			e_rd_vld_q <= edge_vld_q[e_raddr];
			if (c_we) cnt_vld_q[c_waddr] <= 1'b1;
			c_rd_vld_q <= cnt_vld_q[c_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= fifo_cmd;
		if (state_q == S_QWAIT) begin
			ptime_q <= qt_rd_q;
			pch_q   <= qc_rd_q;
		end
		if (state_q == S_BLO) lo_edge_q <= hi_edge;
		if (state_q == S_BHI) begin
			hit_q     <= hit;
			hi_edge_q <= hi_edge;
		end
		if (state_q == S_BUPD) lo_edge_q <= hi_edge_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			fill_q       <= '0;
			front_q      <= '0;
			back_q       <= '0;
			started_q    <= 1'b0;
			error_q      <= 1'b0;
			flushed_q    <= 1'b0;
			flush_mode_q <= 1'b0;
			bin_q        <= '0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			count_q      <= '0;
			level_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) state_q <= S_EXEC;
				end
				S_EXEC: begin
					status_q <= error_q ? ST_ERROR : ST_OK;
					count_q  <= '0;
					level_q  <= fill_q;
					case (cmd_q.op)
						OP_LOAD: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						OP_READ: state_q <= S_READ;
						default: begin
							if (flushed_q) begin
								status_q <= ST_IGNORED;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (error_q) begin
								if (cmd_q.op == OP_FLUSH) flushed_q <= 1'b1;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else if (cmd_q.op == OP_FLUSH) begin
								flushed_q    <= 1'b1;
								flush_mode_q <= 1'b1;
								state_q      <= S_DCHK;
							end else if (early) begin
								status_q <= ST_DROPPED;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (!q_we) begin
								// queue full: sticky error
								error_q  <= 1'b1;
								status_q <= ST_ERROR;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								fill_q    <= fill_q + 1'b1;
								started_q <= 1'b1;
								if (!started_q) begin
									front_q <= cfg.start_enable ? cfg.start_stamp
										: cmd_q.photon_time;
								end
								back_q <= cfg.stop_enable ? cfg.stop_stamp : cmd_q.photon_time;
								flush_mode_q <= 1'b0;
								state_q      <= S_DCHK;
							end
						end
					endcase
				end
				S_READ: begin
					count_q <= (cmd_q.read_ok && c_rd_vld_q) ? c_rd_q : '0;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DCHK: begin
					if (fill_q == '0) begin
						status_q <= ST_OK;
						count_q  <= '0;
						level_q  <= fill_q;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_QWAIT;
					end
				end
				S_QWAIT: begin
					if (due) begin
						head_q  <= head_q + 1'b1;
						fill_q  <= fill_q - 1'b1;
						bin_q   <= '0;
						state_q <= S_BLO;
					end else begin
						status_q <= ST_OK;
						count_q  <= '0;
						level_q  <= fill_q;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_BLO: state_q <= S_BHI;
				S_BHI: state_q <= S_BUPD;
				S_BUPD: begin
					if (bin_q == BIN_W'(BINS-1)) begin
						state_q <= S_DCHK;
					end else begin
						bin_q   <= bin_q + 1'b1;
						state_q <= S_BHI;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/photon_intensity_binner.sv =====
// Top level of the photon intensity binner: APB registers, front, queue, back.
// Depends on pib_pkg, pib_front, pib_cmd_fifo, pib_back.
//
// Usage: a command beat (opcode plus fields) is taken when start is high and
// busy is low. Opcodes load a bin edge, enter a photon, flush the delay queue
// or read a count. Each beat yields exactly one result, shown for one cycle
// with done high; the receiver cannot stall it.
// A photon or flush result comes only after the back end has binned every
// photon that it releases from the delay queue.
// One beat is worked at a time by the back end; the front and a two-beat
// command queue take up to three beats ahead while it works.
// Reset clears the edge table, count table (by valid bits), queue pointers,
// limits and flags at once; no clearing pass. Registers sit on an APB port
// at byte address 8*i. They are to be written only while the block is idle;
// the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module photon_intensity_binner import pib_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               opcode,
	input  wire logic [TIME_W-1:0]        photon_time,
	input  wire logic [CH_W-1:0]          photon_channel,
	input  wire logic [EIDX_W-1:0]        edge_index,
	input  wire logic signed [EDGE_W-1:0] edge_value,
	input  wire logic [BIN_W-1:0]         bin_index,
	input  wire logic [CH_W-1:0]          read_channel,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [COUNT_W-1:0]            count_value,
	output logic [LVL_W-1:0]              queue_level,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [5:0]               paddr,
	input  wire logic [63:0]              pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready
);
	cfg_t cfg_q;
	logic [2:0] reg_idx;
	logic wr_en;
	logic fifo_full, fifo_empty, push, pop;
	cmd_t front_cmd, head_cmd;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_START_EN:   cfg_q.start_enable <= pwdata[0];
				REG_START_TIME: cfg_q.start_stamp  <= pwdata[TIME_W-1:0];
				REG_STOP_EN:    cfg_q.stop_enable  <= pwdata[0];
				REG_STOP_TIME:  cfg_q.stop_stamp   <= pwdata[TIME_W-1:0];
				REG_MAX_DELAY:  cfg_q.max_delay    <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_START_EN:   prdata = {63'd0, cfg_q.start_enable};
			REG_START_TIME: prdata = {16'd0, cfg_q.start_stamp};
			REG_STOP_EN:    prdata = {63'd0, cfg_q.stop_enable};
			REG_STOP_TIME:  prdata = {16'd0, cfg_q.stop_stamp};
			REG_MAX_DELAY:  prdata = {16'd0, cfg_q.max_delay};
			default:        prdata = '0;
		endcase
	end

	pib_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.opcode         (opcode),
		.photon_time    (photon_time),
		.photon_channel (photon_channel),
		.edge_index     (edge_index),
		.edge_value     (edge_value),
		.bin_index      (bin_index),
		.read_channel   (read_channel),
		.fifo_full      (fifo_full),
		.busy           (busy),
		.push           (push),
		.cmd            (front_cmd)
	);

	pib_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.full     (fifo_full),
		.empty    (fifo_empty),
		.head_cmd (head_cmd)
	);

	pib_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.fifo_empty  (fifo_empty),
		.fifo_cmd    (head_cmd),
		.pop         (pop),
		.done        (done),
		.status      (status),
		.count_value (count_value),
		.queue_level (queue_level)
	);
endmodule
`default_nettype wire

// ===== design/pib_checker.sv =====
// Port-level checks of the photon intensity binner, bound to the top level.
// Depends on pib_pkg and photon_intensity_binner_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "photon_intensity_binner_defines.svh"
module pib_checker import pib_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic [1:0]         status,
	input wire logic [COUNT_W-1:0] count_value,
	input wire logic [LVL_W-1:0]   queue_level,
	input wire logic               pready
);
	// one item at a time in the back end: never two result beats in a row
	`PIB_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`PIB_ASSERT_IMPLY(a_level_range, clk, arst_n, done, queue_level <= LVL_W'(QUEUE_DEPTH))
	`PIB_ASSERT_IMPLY(a_drop_no_count, clk, arst_n,
		done && (status == ST_DROPPED || status == ST_IGNORED), count_value == '0)
	`PIB_ASSERT_IMPLY(a_busy_no_take, clk, arst_n, busy, !(start && !busy))
	`PIB_ASSERT_IMPLY(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind photon_intensity_binner pib_checker u_chk (.*);
`default_nettype wire

// ===== tb/photon_intensity_binner_checker.sv =====
// Scoreboard for the photon intensity binner: watches the command, result
// and APB channels, predicts every result and compares. Depends on pib_pkg.
`timescale 1ns / 1ps
module photon_intensity_binner_checker import pib_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [1:0]               opcode,
	input  logic [TIME_W-1:0]        photon_time,
	input  logic [CH_W-1:0]          photon_channel,
	input  logic [EIDX_W-1:0]        edge_index,
	input  logic signed [EDGE_W-1:0] edge_value,
	input  logic [BIN_W-1:0]         bin_index,
	input  logic [CH_W-1:0]          read_channel,
	input  logic                     done,
	input  logic [1:0]               status,
	input  logic [COUNT_W-1:0]       count_value,
	input  logic [LVL_W-1:0]         queue_level,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [5:0]               paddr,
	input  logic [63:0]              pwdata,
	output int                       errors,
	output int                       pending,
	output int                       fill_level
);
	typedef struct {
		logic [1:0]         st;
		logic [COUNT_W-1:0] cnt;
		logic [LVL_W-1:0]   lvl;
	} bin_result_t;

	bin_result_t        result_q[$];
	int                 n_taken, n_returned;
	cfg_t               cfg;
	int                 edges[BINS+1];
	logic [COUNT_W-1:0] counts[CNT_DEPTH];
	logic [TIME_W-1:0]  fifo_time[QUEUE_DEPTH];
	logic [CH_W-1:0]    fifo_ch[QUEUE_DEPTH];
	int                 head, fill;
	longint             front, back;
	bit                 started, err, flushed;

	assign pending    = n_taken - n_returned;
	assign fill_level = fill;

	function automatic bit in_window(longint v);
		return front <= v && v < back;
	endfunction

	function automatic void bin_photon(logic [TIME_W-1:0] t, logic [CH_W-1:0] ch);
		longint lo, hi;
		int idx;
		if (ch >= CHANNELS)
			return;
		for (int i = 0; i < BINS; i++) begin
			lo = longint'({16'd0, t}) + longint'(edges[i]);
			hi = longint'({16'd0, t}) + longint'(edges[i+1]);
			if (in_window(lo) || in_window(hi)) begin
				idx = i * CHANNELS + ch;
				if (counts[idx] != '1)
					counts[idx] = counts[idx] + 1'b1;
			end
		end
	endfunction

	function automatic void release_head();
		bin_photon(fifo_time[head], fifo_ch[head]);
		head = (head + 1) % QUEUE_DEPTH;
		fill--;
	endfunction

	function automatic logic [1:0] take_photon(logic [TIME_W-1:0] t, logic [CH_W-1:0] ch);
		int slot;
		if (!started && cfg.start_enable && t < cfg.start_stamp)
			return ST_DROPPED;
		if (fill >= QUEUE_DEPTH) begin
			err = 1;
			return ST_ERROR;
		end
		slot = (head + fill) % QUEUE_DEPTH;
		fifo_time[slot] = t;
		fifo_ch[slot] = ch;
		fill++;
		if (!started) begin
			started = 1;
			front = cfg.start_enable ? longint'({16'd0, cfg.start_stamp})
				: longint'({16'd0, t});
		end
		back = cfg.stop_enable ? longint'({16'd0, cfg.stop_stamp}) : longint'({16'd0, t});
		while (fill > 0 &&
		       back - longint'({16'd0, fifo_time[head]}) > longint'({16'd0, cfg.max_delay}))
			release_head();
		return ST_OK;
	endfunction

	function automatic bin_result_t predict_result();
		bin_result_t r;
		r.st = ST_OK;
		r.cnt = '0;
		case (opcode_t'(opcode))
			OP_LOAD: begin
				if (edge_index <= BINS)
					edges[edge_index] = int'(edge_value);
				r.st = err ? ST_ERROR : ST_OK;
			end
			OP_READ: begin
				if (bin_index < BINS && read_channel < CHANNELS)
					r.cnt = counts[bin_index * CHANNELS + read_channel];
				r.st = err ? ST_ERROR : ST_OK;
			end
			default: begin
				if (flushed)
					r.st = ST_IGNORED;
				else if (err) begin
					if (opcode_t'(opcode) == OP_FLUSH)
						flushed = 1;
					r.st = ST_ERROR;
				end else if (opcode_t'(opcode) == OP_PHOTON)
					r.st = take_photon(photon_time, photon_channel);
				else begin
					while (fill > 0)
						release_head();
					flushed = 1;
				end
			end
		endcase
		r.lvl = fill[LVL_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bin_result_t e;
		if (!arst_n) begin
			cfg = '0;
			foreach (edges[i]) edges[i] = 0;
			foreach (counts[i]) counts[i] = '0;
			head = 0; fill = 0; front = 0; back = 0;
			started = 0; err = 0; flushed = 0;
			result_q.delete();
			n_taken = 0; n_returned = 0; errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_START_EN:   cfg.start_enable = pwdata[0];
					REG_START_TIME: cfg.start_stamp  = pwdata[TIME_W-1:0];
					REG_STOP_EN:    cfg.stop_enable  = pwdata[0];
					REG_STOP_TIME:  cfg.stop_stamp   = pwdata[TIME_W-1:0];
					REG_MAX_DELAY:  cfg.max_delay    = pwdata[TIME_W-1:0];
					default: ;
				endcase
			end
			if (done) begin
				n_returned++;
				if (result_q.size() == 0) begin
					$display("%0t: result beat with nothing expected", $time);
					errors++;
				end else begin
					e = result_q.pop_front();
					if (status !== e.st) begin
						$display("%0t: status exp %0d got %0d", $time, e.st, status);
						errors++;
					end
					if (count_value !== e.cnt) begin
						$display("%0t: count_value exp %0d got %0d", $time, e.cnt,
							count_value);
						errors++;
					end
					if (queue_level !== e.lvl) begin
						$display("%0t: queue_level exp %0d got %0d", $time, e.lvl,
							queue_level);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				result_q.push_back(predict_result());
				n_taken++;
			end
		end
	end
endmodule

// ===== tb/photon_intensity_binner_tb.sv =====
// Testbench top for the photon intensity binner: clock, reset, APB setup,
// command stimulus and verdict. Depends on pib_pkg, the block and its checker.
`timescale 1ns / 1ps
module photon_intensity_binner_tb;
	import pib_pkg::*;

	logic                     clk = 0;
	logic                     arst_n = 0;
	logic                     start = 0;
	logic                     busy;
	logic [1:0]               opcode = OP_LOAD;
	logic [TIME_W-1:0]        photon_time = '0;
	logic [CH_W-1:0]          photon_channel = '0;
	logic [EIDX_W-1:0]        edge_index = '0;
	logic signed [EDGE_W-1:0] edge_value = '0;
	logic [BIN_W-1:0]         bin_index = '0;
	logic [CH_W-1:0]          read_channel = '0;
	logic                     done;
	logic [1:0]               status;
	logic [COUNT_W-1:0]       count_value;
	logic [LVL_W-1:0]         queue_level;
	logic                     psel = 0, penable = 0, pwrite = 0;
	logic [5:0]               paddr = '0;
	logic [63:0]              pwdata = '0;
	logic [63:0]              prdata;
	logic                     pready;
	int                       errors, pending, fill_level;
	int                       idle_pct = 0;
	int                       stall_cycles = 0;
	logic [TIME_W-1:0]        now_base = 48'd2000;

	always #5 clk = ~clk;

	photon_intensity_binner dut (.*);
	photon_intensity_binner_checker chk (.*);

	// watchdog: cycles with no beat on any channel
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= 40000) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic drain_wait();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic issue(input opcode_t op, input logic [TIME_W-1:0] t,
			input logic [CH_W-1:0] ch, input logic [EIDX_W-1:0] ei,
			input logic [EDGE_W-1:0] ev, input logic [BIN_W-1:0] bi,
			input logic [CH_W-1:0] rc);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		opcode <= op; photon_time <= t; photon_channel <= ch; edge_index <= ei;
		edge_value <= ev; bin_index <= bi; read_channel <= rc; start <= 1;
		do @(posedge clk); while (busy);
	endtask

	task automatic photon(input logic [TIME_W-1:0] t, input logic [CH_W-1:0] ch);
		issue(OP_PHOTON, t, ch, EIDX_W'($urandom), $urandom, BIN_W'($urandom),
			CH_W'($urandom));
	endtask

	task automatic read_count(input logic [BIN_W-1:0] bi, input logic [CH_W-1:0] rc);
		issue(OP_READ, TIME_W'({$urandom, $urandom}), CH_W'($urandom), EIDX_W'($urandom),
			$urandom, bi, rc);
	endtask

	task automatic random_item();
		int pick;
		logic [EDGE_W-1:0] ev;
		logic [TIME_W-1:0] t;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			ev = ($urandom_range(0, 9) == 0) ? $urandom
				: EDGE_W'($signed($urandom_range(0, 4000)) - 2000);
			issue(OP_LOAD, TIME_W'({$urandom, $urandom}), CH_W'($urandom),
				($urandom_range(0, 9) == 0) ? EIDX_W'($urandom) : EIDX_W'($urandom_range(0, BINS)),
				ev, BIN_W'($urandom), CH_W'($urandom));
		end else if (pick < 40) begin
			read_count(BIN_W'($urandom), CH_W'($urandom));
		end else begin
			now_base = now_base + TIME_W'($urandom_range(0, 400));
			t = ($urandom_range(0, 29) == 0) ? TIME_W'({$urandom, $urandom}) : now_base;
			photon(t, CH_W'($urandom));
		end
	endtask

	initial begin
		int modes[5] = '{0, 47, 9, 0, 47};
		logic [63:0] delays[5];
		int n;
		delays = '{64'd0, 64'd300, 64'd5000, 64'hFFFF_FFFF_FFFF, 64'd800};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		reg_write(REG_START_EN, 64'd1);
		reg_write(REG_START_TIME, 64'd1000);
		reg_write(REG_STOP_EN, 64'd0);
		reg_write(REG_STOP_TIME, 64'd0);
		reg_write(REG_MAX_DELAY, 64'd100);

		// directed: edge extremes, out-of-range load, drop before start
		issue(OP_LOAD, '0, '0, 5'd0, 32'sh8000_0000, '0, '0);
		issue(OP_LOAD, '0, '0, 5'd16, 32'sh7FFF_FFFF, '0, '0);
		issue(OP_LOAD, '0, '0, 5'd31, 32'sh1234_5678, '0, '0);
		issue(OP_LOAD, '0, '0, 5'd17, 32'sh0000_0010, '0, '0);
		issue(OP_LOAD, '0, '0, 5'd1, -32'sd50, '0, '0);
		issue(OP_LOAD, '0, '0, 5'd2, 32'sd50, '0, '0);
		photon(48'd0, 2'd0);
		photon(48'd999, 2'd3);
		photon(48'd1000, 2'd0);
		photon(48'd1050, 2'd1);
		photon(48'd1100, 2'd3);
		photon(48'd1400, 2'd2);
		read_count(4'd0, 2'd0);
		read_count(4'd1, 2'd1);
		read_count(4'd15, 2'd3);
		read_count(4'd2, 2'd3);
		drain_wait();

		for (int ph = 0; ph < 5; ph++) begin
			reg_write(REG_START_EN, 64'($urandom_range(0, 1)));
			reg_write(REG_START_TIME, {$urandom, $urandom});
			reg_write(REG_STOP_EN, (ph == 2) ? 64'd1 : 64'd0);
			reg_write(REG_STOP_TIME, (ph == 2) ? 64'(now_base + 48'd20000) : 64'hFFFF_FFFF_FFFF);
			reg_write(REG_MAX_DELAY, delays[ph]);
			idle_pct = modes[ph];
			repeat (110) random_item();
			drain_wait();
		end

		// fill the delay queue to the brim, then flush it all
		idle_pct = 9;
		reg_write(REG_STOP_EN, 64'd0);
		reg_write(REG_MAX_DELAY, 64'hFFFF_FFFF_FFFF);
		while (fill_level < QUEUE_DEPTH) begin
			n = QUEUE_DEPTH - fill_level;
			repeat (n) begin
				now_base = now_base + TIME_W'($urandom_range(0, 300));
				photon(now_base, CH_W'($urandom));
			end
			drain_wait();
		end
		issue(OP_FLUSH, '0, '0, '0, '0, '0, '0);
		for (int b = 0; b < BINS; b++)
			for (int c = 0; c < CHANNELS; c++)
				read_count(BIN_W'(b), CH_W'(c));
		photon(48'hFFFF_FFFF_FFFF, 2'd3);
		issue(OP_FLUSH, '0, '0, '0, '0, '0, '0);
		repeat (20) random_item();

		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
